/* design/gasp_pkg.sv */
package gasp_pkg;

    // Page count and the widths that follow from it
    localparam int MAX_PAGES  = 8;
    localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);

    // Fixed field widths
    localparam int DIM_W      = 13;
    localparam int RECT_W     = 12;
    localparam int PAGE_OUT_W = 3;
    localparam int SUM_W      = DIM_W + 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] ATLAS_RESET_SIZE = 13'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'b1;

    // Per-page shelf record held in the page memory
    typedef struct packed {
        logic [DIM_W-1:0] cursor_x;
        logic [DIM_W-1:0] shelf_top;
        logic [DIM_W-1:0] shelf_bottom;
    } shelf_t;

    localparam int SHELF_W = $bits(shelf_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic next_page;
        logic eval_wrap;
        logic mark_full;
        logic open_page;
        logic calc_place;
        logic commit;
        logic load_no_space;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic page_is_full;
        logic fits;
        logic all_used;
    } dp_status_t;

endpackage

/* design/gasp_ram.sv */
module gasp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/gasp_ctrl.sv */
module gasp_ctrl import gasp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_READ     = 8'b0000_0100,
        S_FIT      = 8'b0000_1000,
        S_OPEN     = 8'b0001_0000,
        S_PLACE    = 8'b0010_0000,
        S_COMMIT   = 8'b0100_0000,
        S_NO_SPACE = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_busy;

    // Output register is free when empty or being taken this cycle
    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_OPEN;
                end
                else if (status.page_is_full)
                begin
                    cmd.next_page = 1'b1;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.eval_wrap = 1'b1;
                state_next    = S_FIT;
            end
            S_FIT:
            begin
                if (status.fits)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.mark_full = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_OPEN:
            begin
                if (status.all_used)
                begin
                    state_next = S_NO_SPACE;
                end
                else
                begin
                    cmd.open_page = 1'b1;
                    state_next    = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.calc_place = 1'b1;
                state_next     = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Hold until the output register can take the result
                if (!out_busy)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_NO_SPACE:
            begin
                if (!out_busy)
                begin
                    cmd.load_no_space = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/gasp_datapath.sv */
module gasp_datapath import gasp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic [RECT_W-1:0]     rect_width,
    input  logic [RECT_W-1:0]     rect_height,
    output logic [PAGE_OUT_W-1:0] page_index,
    output logic [DIM_W-1:0]      place_x,
    output logic [DIM_W-1:0]      place_y,
    output logic                  opened_page,
    output logic                  no_space
);

    // Configuration
    logic [DIM_W-1:0] atlas_width_reg;
    logic [DIM_W-1:0] atlas_height_reg;

    // Request and scan state
    logic [RECT_W-1:0]     w_reg;
    logic [RECT_W-1:0]     h_reg;
    logic [PAGE_CNT_W-1:0] page_reg;
    logic [PAGE_CNT_W-1:0] used_reg;
    logic [MAX_PAGES-1:0]  full_reg;
    logic [DIM_W-1:0]      cur_reg;
    logic [DIM_W-1:0]      top_reg;
    logic [DIM_W-1:0]      bot_reg;
    logic [DIM_W-1:0]      px_reg;
    logic [DIM_W-1:0]      py_reg;
    logic                  opened_reg;

    // Result register
    logic [PAGE_OUT_W-1:0] page_index_reg;
    logic [DIM_W-1:0]      place_x_reg;
    logic [DIM_W-1:0]      place_y_reg;
    logic                  opened_page_reg;
    logic                  no_space_reg;

    logic [PAGE_IDX_W-1:0] page_idx;
    logic [PAGE_IDX_W-1:0] used_idx;
    logic [PAGE_IDX_W+PAGE_OUT_W-1:0] page_ext;
    shelf_t                rd_shelf;
    shelf_t                wr_shelf;
    logic                  wr_en;
    logic [SUM_W-1:0]      wrap_sum;
    logic                  wrap;
    logic [SUM_W-1:0]      fit_sum;
    logic [SUM_W-1:0]      bot_sum;
    logic [DIM_W-1:0]      new_bot;
    logic [SUM_W-1:0]      cur_sum;

    assign page_idx = page_reg[PAGE_IDX_W-1:0];
    assign used_idx = used_reg[PAGE_IDX_W-1:0];
    assign page_ext = {{PAGE_OUT_W{1'b0}}, page_idx};

    // Status back to the controller
    assign fit_sum = SUM_W'(top_reg) + SUM_W'(h_reg) + SUM_W'(1);
    assign status.scan_done    = (page_reg == used_reg);
    assign status.page_is_full = full_reg[page_idx];
    assign status.fits         = (fit_sum < SUM_W'(atlas_height_reg));
    assign status.all_used     = (used_reg == PAGE_CNT_W'(MAX_PAGES));

    // Wrap test on the record just read
    assign wrap_sum = SUM_W'(rd_shelf.cursor_x) + SUM_W'(w_reg) + SUM_W'(1);
    assign wrap     = (wrap_sum > SUM_W'(atlas_width_reg));

    // Placement update: lower shelf bottom, advance cursor
    assign bot_sum = SUM_W'(py_reg) + SUM_W'(h_reg);
    assign new_bot = (SUM_W'(bot_reg) < bot_sum) ? bot_sum[DIM_W-1:0] : bot_reg;
    assign cur_sum = SUM_W'(px_reg) + SUM_W'(w_reg);

    // Write back the record on a full mark or a placement
    always_comb
    begin
        wr_en                 = cmd.mark_full || cmd.commit;
        wr_shelf.cursor_x     = cur_reg;
        wr_shelf.shelf_top    = top_reg;
        wr_shelf.shelf_bottom = bot_reg;
        if (cmd.commit)
        begin
            wr_shelf.cursor_x     = cur_sum[DIM_W-1:0];
            wr_shelf.shelf_bottom = new_bot;
        end
    end

    gasp_ram #(
        .WIDTH  (SHELF_W),
        .DEPTH  (MAX_PAGES),
        .ADDR_W (PAGE_IDX_W)
    ) u_shelf_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (page_idx),
        .wr_data (wr_shelf),
        .rd_addr (page_idx),
        .rd_data (rd_shelf)
    );

    // Control state: configuration, page pointer, page count, full flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg  <= ATLAS_RESET_SIZE;
            atlas_height_reg <= ATLAS_RESET_SIZE;
            page_reg         <= '0;
            used_reg         <= '0;
            full_reg         <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_ATLAS_WIDTH:  atlas_width_reg  <= cfg_data;
                    REG_ATLAS_HEIGHT: atlas_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.load_item)
            begin
                page_reg <= '0;
            end
            if (cmd.next_page)
            begin
                page_reg <= page_reg + PAGE_CNT_W'(1);
            end
            if (cmd.mark_full)
            begin
                full_reg[page_idx] <= 1'b1;
                page_reg           <= page_reg + PAGE_CNT_W'(1);
            end
            if (cmd.open_page)
            begin
                full_reg[used_idx] <= 1'b0;
                page_reg           <= used_reg;
                used_reg           <= used_reg + PAGE_CNT_W'(1);
            end
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            w_reg      <= rect_width;
            h_reg      <= rect_height;
            opened_reg <= 1'b0;
        end
        if (cmd.eval_wrap)
        begin
            cur_reg <= wrap ? '0 : rd_shelf.cursor_x;
            top_reg <= wrap ? rd_shelf.shelf_bottom : rd_shelf.shelf_top;
            bot_reg <= rd_shelf.shelf_bottom;
        end
        if (cmd.open_page)
        begin
            cur_reg    <= '0;
            top_reg    <= '0;
            bot_reg    <= '0;
            opened_reg <= 1'b1;
        end
        if (cmd.calc_place)
        begin
            px_reg <= cur_reg + DIM_W'(1);
            py_reg <= top_reg + DIM_W'(1);
        end
        if (cmd.commit)
        begin
            page_index_reg  <= page_ext[PAGE_OUT_W-1:0];
            place_x_reg     <= px_reg;
            place_y_reg     <= py_reg;
            opened_page_reg <= opened_reg;
            no_space_reg    <= 1'b0;
        end
        if (cmd.load_no_space)
        begin
            page_index_reg  <= '0;
            place_x_reg     <= '0;
            place_y_reg     <= '0;
            opened_page_reg <= 1'b0;
            no_space_reg    <= 1'b1;
        end
    end

    assign page_index  = page_index_reg;
    assign place_x     = place_x_reg;
    assign place_y     = place_y_reg;
    assign opened_page = opened_page_reg;
    assign no_space    = no_space_reg;

endmodule

/* design/glyph_atlas_shelf_packer.sv */
// Shelf packer for glyph atlas pages.
// Input channel (in_valid/in_ready) carries one request: rect_width, rect_height.
// Output channel (out_valid/out_ready) returns one result per request:
// page_index, place_x, place_y, opened_page, no_space.
// Configuration: cfg_write_en with cfg_index 0 sets atlas_width, 1 sets
// atlas_height; write only while no request is in flight.
// Each request scans the used pages in order: a page flagged full is
// skipped, and an open page has its shelf record read and checked, and is
// flagged full if the rectangle does not fit. The rectangle is then placed on
// the first page that fits, or a new page is opened, or no space is reported.
// The pages are visited one at a time through a shelf record memory with one
// write port and one registered read port. A new request is accepted in the
// cycle after the previous result is loaded, and not while one is in work.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and scanned, and its placement waits until the
// pending result is taken.
// Reset clears the page count, page-full flags and the result valid, and sets
// both atlas dimensions to 256; page records are rebuilt when a page opens.
module glyph_atlas_shelf_packer import gasp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RECT_W-1:0]     rect_width,
    input  logic [RECT_W-1:0]     rect_height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PAGE_OUT_W-1:0] page_index,
    output logic [DIM_W-1:0]      place_x,
    output logic [DIM_W-1:0]      place_y,
    output logic                  opened_page,
    output logic                  no_space,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gasp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gasp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .page_index   (page_index),
        .place_x      (place_x),
        .place_y      (place_y),
        .opened_page  (opened_page),
        .no_space     (no_space)
    );

endmodule

/* sim/tb_glyph_atlas_shelf_packer.sv */
module tb_glyph_atlas_shelf_packer import gasp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;
    localparam int unsigned DIM_MASK = (1 << DIM_W) - 1;

    typedef struct packed {
        logic [RECT_W-1:0] w;
        logic [RECT_W-1:0] h;
    } rect_req_t;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0] page;
        logic [DIM_W-1:0]      x;
        logic [DIM_W-1:0]      y;
        logic                  opened;
        logic                  full_stop;
    } placement_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [RECT_W-1:0]     rect_width   = '0;
    logic [RECT_W-1:0]     rect_height  = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [PAGE_OUT_W-1:0] page_index;
    logic [DIM_W-1:0]      place_x;
    logic [DIM_W-1:0]      place_y;
    logic                  opened_page;
    logic                  no_space;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [DIM_W-1:0]      cfg_data     = '0;

    // Packer model state
    int unsigned model_width;
    int unsigned model_height;
    int unsigned pages_open;
    int unsigned pg_cursor [MAX_PAGES];
    int unsigned pg_top    [MAX_PAGES];
    int unsigned pg_bottom [MAX_PAGES];
    bit          pg_full   [MAX_PAGES];

    rect_req_t  pending_rects[$];
    placement_t placements_due[$];

    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int cycles       = 0;
    int burst_left;
    int idle_left;
    int unsigned stall_tick;

    rect_req_t  next_req;
    placement_t want;
    placement_t seen;

    glyph_atlas_shelf_packer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .page_index  (page_index),
        .place_x     (place_x),
        .place_y     (place_y),
        .opened_page (opened_page),
        .no_space    (no_space),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Work out where one rectangle lands and update the page records
    function automatic placement_t place_rect(input logic [RECT_W-1:0] rw,
                                              input logic [RECT_W-1:0] rh);
        placement_t  res;
        int unsigned w;
        int unsigned h;
        int unsigned sel;
        int unsigned px;
        int unsigned py;
        int unsigned bot;
        bit          found;
        bit          opened;
        res    = '0;
        w      = rw;
        h      = rh;
        sel    = 0;
        found  = 1'b0;
        opened = 1'b0;
        for (int unsigned p = 0; p < pages_open && p < MAX_PAGES; p++)
        begin
            if (!found && !pg_full[p])
            begin
                // wrap to a new shelf when the row is used up
                if (pg_cursor[p] + w + 1 > model_width)
                begin
                    pg_cursor[p] = 0;
                    pg_top[p]    = pg_bottom[p];
                end
                if (pg_top[p] + h + 1 < model_height)
                begin
                    sel   = p;
                    found = 1'b1;
                end
                else
                    pg_full[p] = 1'b1;
            end
        end
        if (!found && pages_open >= MAX_PAGES)
            res.full_stop = 1'b1;
        else
        begin
            // open a fresh page when nothing took the rectangle
            if (!found)
            begin
                sel            = pages_open;
                pages_open     = pages_open + 1;
                pg_cursor[sel] = 0;
                pg_top[sel]    = 0;
                pg_bottom[sel] = 0;
                pg_full[sel]   = 1'b0;
                opened         = 1'b1;
            end
            px  = (pg_cursor[sel] + 1) & DIM_MASK;
            py  = (pg_top[sel] + 1) & DIM_MASK;
            bot = py + h;
            if (pg_bottom[sel] < bot)
                pg_bottom[sel] = bot & DIM_MASK;
            pg_cursor[sel] = (px + w) & DIM_MASK;
            res.page   = sel[PAGE_OUT_W-1:0];
            res.x      = px[DIM_W-1:0];
            res.y      = py[DIM_W-1:0];
            res.opened = opened;
        end
        return res;
    endfunction

    task automatic add_rect(input int unsigned w, input int unsigned h);
        rect_req_t r;
        r.w = w[RECT_W-1:0];
        r.h = h[RECT_W-1:0];
        pending_rects = {pending_rects, r};
        items_sent++;
    endtask

    // Queue random rectangles, mostly small, a quarter of them any width
    task automatic queue_rects(input int n, input int unsigned w_cap, input int unsigned h_cap);
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_rect($urandom_range(0, 4095), $urandom_range(0, h_cap));
            else
                add_rect($urandom_range(0, w_cap), $urandom_range(0, h_cap));
        end
    endtask

    // Hold until every request has its result, then let the block go quiet
    task automatic settle();
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[DIM_W-1:0];
        if (idx == REG_ATLAS_WIDTH)
            model_width = value & DIM_MASK;
        else
            model_height = value & DIM_MASK;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_atlas(input int unsigned w, input int unsigned h);
        write_reg(REG_ATLAS_WIDTH, w);
        write_reg(REG_ATLAS_HEIGHT, h);
    endtask

    // Request driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = $urandom_range(1, 40);
            idle_left  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                placements_due = {placements_due, place_rect(rect_width, rect_height)};
            if (!in_valid || in_ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_rects.size() > 0)
                begin
                    next_req = pending_rects.pop_front();
                    rect_width  <= next_req.w;
                    rect_height <= next_req.h;
                    in_valid    <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_tick = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                seen = '{page_index, place_x, place_y, opened_page, no_space};
                if (placements_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"unexpected result: page %0d x %0d y %0d",
                                  " opened %0b no_space %0b"},
                                 seen.page, seen.x, seen.y, seen.opened, seen.full_stop);
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result %0d mismatch: exp page %0d x %0d y %0d",
                                      " opened %0b ns %0b, got page %0d x %0d y %0d",
                                      " opened %0b ns %0b"},
                                     results_seen, want.page, want.x, want.y, want.opened,
                                     want.full_stop, seen.page, seen.x, seen.y, seen.opened,
                                     seen.full_stop);
                    end
                end
            end
            // switch receiver behavior on bits 8:7 of the stall tick count
            stall_tick++;
            case (stall_tick[8:7])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
                default: out_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_glyph_atlas_shelf_packer: done, errors");
            $finish;
        end
    end

    initial
    begin
        model_width  = ATLAS_RESET_SIZE;
        model_height = ATLAS_RESET_SIZE;
        pages_open   = 0;
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            pg_cursor[p] = 0;
            pg_top[p]    = 0;
            pg_bottom[p] = 0;
            pg_full[p]   = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset-size atlas
        add_rect(0, 0);         // empty rectangle opens the first page
        add_rect(10, 20);
        add_rect(243, 5);       // ends exactly at the right edge, no wrap
        add_rect(1, 1);         // wraps to the next shelf
        add_rect(4095, 3);      // wider than the page, placed after a wrap
        add_rect(5, 231);       // too tall after wrap: page full, new page
        add_rect(7, 22);
        add_rect(3, 232);
        add_rect(2, 254);       // last height that still fits
        add_rect(2730, 1365);
        add_rect(1365, 2730);
        add_rect(4095, 4095);   // fills every page, new page with no size check
        add_rect(0, 0);
        settle();

        // Large 4096 by 4096 pages, with one full drain midway
        set_atlas(4096, 4096);
        queue_rects(150, 63, 31);
        settle();
        queue_rects(180, 63, 31);
        settle();

        // Narrowest pages, tall
        write_reg(REG_ATLAS_WIDTH, 16);
        queue_rects(100, 15, 15);
        settle();

        // Wide, medium height
        set_atlas(4096, 1024);
        queue_rects(150, 63, 47);
        settle();

        // Smallest pages
        set_atlas(16, 16);
        queue_rects(60, 5, 5);
        settle();

        // Extreme values: nothing fits, pages run out
        set_atlas(8191, 0);
        queue_rects(40, 4095, 4095);
        settle();

        if (mismatches == 0 && placements_due.size() == 0)
            $display("tb_glyph_atlas_shelf_packer: done, clean");
        else
            $display("tb_glyph_atlas_shelf_packer: done, errors");
        $finish;
    end

endmodule
